// File: rtl/core/ucsr_pkg.sv
// Shared types and constants for the UDP clone-steer header rewriter.
`timescale 1ns / 1ps
package ucsr_pkg;

  localparam int HEADER_BEATS = 11;
  localparam int IDX_W        = $clog2(HEADER_BEATS);
  localparam int AVAIL_W      = $clog2(HEADER_BEATS * 8 + 1);

  localparam logic [15:0] STEER_PORT = 16'd8901;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  localparam logic [1:0] VERDICT_PASS     = 2'd0;
  localparam logic [1:0] VERDICT_CLONE    = 2'd1;
  localparam logic [1:0] VERDICT_TX       = 2'd2;
  localparam logic [1:0] VERDICT_REDIRECT = 2'd3;

  localparam logic [1:0] CFG_CLONE_COUNT     = 2'd0;
  localparam logic [1:0] CFG_REDIRECT_QUEUE  = 2'd1;
  localparam logic [1:0] CFG_REDIRECT_ENABLE = 2'd2;

  typedef struct packed {
    logic [63:0]        beat_data;
    logic [3:0]         beat_bytes;
    logic               beat_last;
    logic signed [31:0] copy_number;
    logic               meta_present;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] out_data;
    logic [3:0]  out_bytes;
    logic        out_last;
    logic [1:0]  verdict;
    logic [26:0] verdict_count;
    logic [5:0]  verdict_queue;
  } out_beat_t;

  // Header fields gathered while the beats stream in.
  typedef struct packed {
    logic [95:0] mac;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [31:0] dst;
    logic [23:0] csum_acc;
  } hdr_fields_t;

endpackage

// File: rtl/core/ucsr_hdr_parse.sv
// Header field capture and running IPv4 checksum over buffered beats.
`timescale 1ns / 1ps
module ucsr_hdr_parse (
  input  logic                      clk,
  input  logic                      beat_we,
  input  logic [ucsr_pkg::IDX_W-1:0] beat_idx,
  input  logic [63:0]               beat_data,
  output ucsr_pkg::hdr_fields_t     fields
);
  import ucsr_pkg::*;

  hdr_fields_t fields_r, fields_nxt;
  logic [3:0]  ihl_eff;
  logic [23:0] term_sum;
  logic [6:0]  ihl_end;
  logic [6:0]  dport_beat;
  logic [5:0]  dport_lane;

  always_comb begin
    logic [6:0]  off;
    logic [15:0] word;
    ihl_eff  = (beat_idx == IDX_W'(1)) ? beat_data[51:48] : fields_r.ihl;
    ihl_end  = 7'd14 + {1'b0, ihl_eff, 2'b00};
    term_sum = 24'd0;
    for (int j = 0; j < 4; j++) begin
      off  = {beat_idx[3:0], 3'b000} + 7'(2 * j);
      word = {beat_data[16*j +: 8], beat_data[16*j+8 +: 8]};
      if (off >= 7'd14 && off < ihl_end && off != 7'd24 && off != 7'd30 &&
          off != 7'd32) begin
        term_sum = term_sum + {8'd0, word};
      end
    end
  end

  assign dport_beat = 7'd2 + {4'd0, fields_r.ihl[3:1]};
  assign dport_lane = fields_r.ihl[0] ? 6'd32 : 6'd0;

  always_comb begin
    fields_nxt = fields_r;
    fields_nxt.csum_acc = ((beat_idx == '0) ? 24'd0 : fields_r.csum_acc) + term_sum;
    case (beat_idx)
      IDX_W'(0): fields_nxt.mac[63:0] = beat_data;
      IDX_W'(1): begin
        fields_nxt.mac[95:64] = beat_data[31:0];
        fields_nxt.etype      = {beat_data[39:32], beat_data[47:40]};
        fields_nxt.ihl        = beat_data[51:48];
      end
      IDX_W'(2): fields_nxt.proto = beat_data[63:56];
      IDX_W'(3): fields_nxt.dst[31:16] = {beat_data[55:48], beat_data[63:56]};
      IDX_W'(4): fields_nxt.dst[15:0]  = {beat_data[7:0], beat_data[15:8]};
      default: ;
    endcase
    if (beat_idx >= IDX_W'(2) && {3'd0, beat_idx} == dport_beat) begin
      fields_nxt.dport = {beat_data[dport_lane +: 8], beat_data[dport_lane + 6'd8 +: 8]};
    end
  end

  always_ff @(posedge clk) begin
    if (beat_we) begin
      fields_r <= fields_nxt;
    end
  end

  assign fields = fields_r;

endmodule

// File: rtl/core/udp_packet_clone_steer_rewriter.sv
// Top level of the IPv4/UDP clone-steer header rewriter.
`timescale 1ns / 1ps
// Packets arrive as 64-bit beats (byte 0 in bits 7:0). Header beats are
// written into an 11-entry header memory while the parser captures fields
// and accumulates the IPv4 header checksum; each buffered beat goes through
// an accept state, then a decide state. Once the verdict is known the
// buffered beats are read back from the memory and sent, each with a read
// state and then an output state, with MAC swap, destination increment, new
// IPv4 checksum and a zeroed UDP checksum patched in on steered copies. A
// steered copy also passes a checksum fold state; the destination add happens
// at the decision. Later beats of the packet transfer straight through the
// output register at one per cycle while the output is not stalled.
// Every beat of a packet carries the same verdict, count and queue, fixed at
// the decision; registers are sampled there.
module udp_packet_clone_steer_rewriter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ucsr_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ucsr_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [26:0]         cfg_wdata
);
  import ucsr_pkg::*;

  typedef enum logic [2:0] {
    S_BUF, S_DECIDE, S_CSUM, S_DRD, S_DOUT, S_FWD
  } state_t;

  state_t state_r;

  // configuration
  logic [26:0] clone_count_r;
  logic [5:0]  redirect_queue_r;
  logic        redirect_enable_r;

  // header memory: data and byte count per beat
  logic [67:0] hdr_mem [HEADER_BEATS];
  logic [67:0] rd_q;

  logic [IDX_W-1:0]   beat_idx_r, drain_idx_r;
  logic [AVAIL_W-1:0] avail_r;
  logic               ended_r, last_r;
  logic [31:0]        copy_r;
  logic               meta_r;
  logic [1:0]         verdict_r;
  logic [26:0]        count_r;
  logic [5:0]         queue_r;
  logic               rewrite_r;
  logic [31:0]        new_dst_r;
  logic [15:0]        csum_r;

  out_beat_t   out_r;
  logic        out_valid_r;

  logic        in_acc, out_free, buf_we, out_load;
  logic [3:0]  bytes_sat;
  hdr_fields_t fields;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_BUF) || (state_r == S_FWD && out_free));
  assign in_acc    = in_valid && !in_stall;
  assign buf_we    = in_acc && state_r == S_BUF;
  assign out_load  = (state_r == S_DOUT && out_free) || (state_r == S_FWD && in_acc);
  assign bytes_sat = (in_data.beat_bytes > 4'd8) ? 4'd8 : in_data.beat_bytes;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  ucsr_hdr_parse u_parse (
    .clk       (clk),
    .beat_we   (buf_we),
    .beat_idx  (beat_idx_r),
    .beat_data (in_data.beat_data),
    .fields    (fields)
  );

  always_ff @(posedge clk) begin
    if (buf_we) begin
      hdr_mem[beat_idx_r] <= {bytes_sat, in_data.beat_data};
    end
    rd_q <= hdr_mem[drain_idx_r];
  end

  // Decision from the fields gathered so far; more_needed holds for another beat.
  logic [1:0] dec_verdict;
  logic       more_needed;
  logic [6:0] udp_end;

  assign udp_end = 7'd22 + {1'b0, fields.ihl, 2'b00};

  always_comb begin
    more_needed = 1'b0;
    dec_verdict = VERDICT_PASS;
    if (7'(avail_r) < 7'd14) begin
      more_needed = !ended_r;
    end else if (fields.etype != ETYPE_IPV4) begin
      dec_verdict = VERDICT_PASS;
    end else if (7'(avail_r) < 7'd34) begin
      more_needed = !ended_r;
    end else if (fields.proto != PROTO_UDP || fields.ihl < 4'd5) begin
      dec_verdict = VERDICT_PASS;
    end else if (7'(avail_r) < udp_end) begin
      more_needed = !ended_r;
    end else if (fields.dport != STEER_PORT || !meta_r) begin
      dec_verdict = VERDICT_PASS;
    end else if (copy_r == 32'd0) begin
      dec_verdict = VERDICT_CLONE;
    end else if (copy_r[31]) begin
      dec_verdict = VERDICT_PASS;
    end else if (redirect_enable_r && !copy_r[0]) begin
      dec_verdict = VERDICT_REDIRECT;
    end else begin
      dec_verdict = VERDICT_TX;
    end
  end

  // Checksum fold over accumulated words plus the new destination address.
  logic [23:0] sum0;
  logic [16:0] fold1;
  logic [16:0] fold2;

  assign sum0  = fields.csum_acc + {8'd0, new_dst_r[31:16]} + {8'd0, new_dst_r[15:0]};
  assign fold1 = {1'b0, sum0[15:0]} + {9'd0, sum0[23:16]};
  assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

  // Patch one drained beat.
  logic [63:0] patched;
  logic [6:0]  udp_ck;
  logic [5:0]  udp_lane;

  assign udp_ck   = 7'd20 + {1'b0, fields.ihl, 2'b00};
  assign udp_lane = udp_ck[2] ? 6'd32 : 6'd0;

  always_comb begin
    patched = rd_q[63:0];
    if (rewrite_r) begin
      case (drain_idx_r)
        IDX_W'(0): patched = {fields.mac[15:0], fields.mac[95:48]};
        IDX_W'(1): patched[31:0] = fields.mac[47:16];
        IDX_W'(3): begin
          patched[7:0]   = csum_r[15:8];
          patched[15:8]  = csum_r[7:0];
          patched[55:48] = new_dst_r[31:24];
          patched[63:56] = new_dst_r[23:16];
        end
        IDX_W'(4): begin
          patched[7:0]  = new_dst_r[15:8];
          patched[15:8] = new_dst_r[7:0];
        end
        default: ;
      endcase
      if ({3'd0, drain_idx_r} == {3'd0, udp_ck[6:3]}) begin
        patched[udp_lane +: 16] = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_BUF;
      clone_count_r     <= '0;
      redirect_queue_r  <= '0;
      redirect_enable_r <= 1'b0;
      beat_idx_r        <= '0;
      drain_idx_r       <= '0;
      out_valid_r       <= 1'b0;
      copy_r            <= '0;
      meta_r            <= 1'b0;
      verdict_r         <= VERDICT_PASS;
      count_r           <= '0;
      queue_r           <= '0;
      rewrite_r         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CLONE_COUNT:     clone_count_r     <= cfg_wdata;
          CFG_REDIRECT_QUEUE:  redirect_queue_r  <= cfg_wdata[5:0];
          CFG_REDIRECT_ENABLE: redirect_enable_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      // hold the output until taken; a new load refills it
      out_valid_r <= out_load || (out_valid_r && out_stall);

      case (state_r)
        S_BUF: begin
          if (in_acc) begin
            if (beat_idx_r == '0) begin
              copy_r  <= in_data.copy_number;
              meta_r  <= in_data.meta_present;
              avail_r <= AVAIL_W'(bytes_sat);
            end else begin
              avail_r <= avail_r + AVAIL_W'(bytes_sat);
            end
            ended_r <= in_data.beat_last || bytes_sat < 4'd8 ||
                       beat_idx_r == IDX_W'(HEADER_BEATS - 1);
            last_r  <= in_data.beat_last;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (more_needed) begin
            beat_idx_r <= beat_idx_r + 1'b1;
            state_r    <= S_BUF;
          end else begin
            verdict_r   <= dec_verdict;
            count_r     <= (dec_verdict == VERDICT_CLONE) ? clone_count_r : '0;
            queue_r     <= (dec_verdict == VERDICT_REDIRECT) ? redirect_queue_r : '0;
            rewrite_r   <= dec_verdict == VERDICT_TX || dec_verdict == VERDICT_REDIRECT;
            new_dst_r   <= fields.dst + copy_r;
            drain_idx_r <= '0;
            state_r     <= (dec_verdict == VERDICT_TX || dec_verdict == VERDICT_REDIRECT)
                           ? S_CSUM : S_DRD;
          end
        end
        S_CSUM: begin
          csum_r  <= ~fold2[15:0];
          state_r <= S_DRD;
        end
        S_DRD: begin
          state_r <= S_DOUT;
        end
        S_DOUT: begin
          if (out_free) begin
            out_r.out_data      <= patched;
            out_r.out_bytes     <= rd_q[67:64];
            out_r.out_last      <= last_r && drain_idx_r == beat_idx_r;
            out_r.verdict       <= verdict_r;
            out_r.verdict_count <= count_r;
            out_r.verdict_queue <= queue_r;
            if (drain_idx_r == beat_idx_r) begin
              beat_idx_r  <= '0;
              drain_idx_r <= '0;
              state_r     <= last_r ? S_BUF : S_FWD;
            end else begin
              drain_idx_r <= drain_idx_r + 1'b1;
              state_r     <= S_DRD;
            end
          end
        end
        S_FWD: begin
          if (in_acc) begin
            out_r.out_data      <= in_data.beat_data;
            out_r.out_bytes     <= bytes_sat;
            out_r.out_last      <= in_data.beat_last;
            out_r.verdict       <= verdict_r;
            out_r.verdict_count <= count_r;
            out_r.verdict_queue <= queue_r;
            if (in_data.beat_last) begin
              state_r <= S_BUF;
            end
          end
        end
        default: state_r <= S_BUF;
      endcase
    end
  end

endmodule
